>>> rtl/core/rrbd_pkg.sv
// Package for the row/column byte deinterleaver.
// Holds field widths, default parameter values, register and status codes and shared structs.
// No dependencies.
package rrbd_pkg;

  localparam int unsigned DEF_MAX_ROWS      = 16;
  localparam int unsigned DEF_ROW_LENGTH    = 255;
  localparam int unsigned DEF_ELEMENT_WIDTH = 8;

  localparam int unsigned RowCountW = 5;
  localparam int unsigned FillW     = 8;
  localparam int unsigned OffsetW   = 8;
  localparam int unsigned LengthW   = 13;
  localparam int unsigned ColW      = 9;
  localparam int unsigned RowW      = 4;
  localparam int unsigned OutColW   = 8;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 13;
  localparam int unsigned StepCntW  = 4;

  localparam logic [StepCntW-1:0] DIV_STEPS = StepCntW'(LengthW);

  localparam logic [RowCountW-1:0] RESET_ROW_COUNT     = RowCountW'(1);
  localparam logic [FillW-1:0]     RESET_FILL_WIDTH    = FillW'(249);
  localparam logic [OffsetW-1:0]   RESET_COLUMN_OFFSET = '0;
  localparam logic [LengthW-1:0]   RESET_TOTAL_LENGTH  = '0;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROW_COUNT,
    REG_FILL_WIDTH,
    REG_COLUMN_OFFSET,
    REG_TOTAL_LENGTH
  } rrbd_reg_e;

  localparam logic [StatusW-1:0] STATUS_OK        = StatusW'(0);
  localparam logic [StatusW-1:0] STATUS_ZERO_DIM  = StatusW'(1);
  localparam logic [StatusW-1:0] STATUS_TOO_WIDE  = StatusW'(2);
  localparam logic [StatusW-1:0] STATUS_TOO_LONG  = StatusW'(3);
  localparam logic [StatusW-1:0] STATUS_TOO_SHORT = StatusW'(4);

  typedef struct packed {
    logic                 busy;
    logic [StatusW-1:0]   status;
    logic [RowCountW-1:0] row_count;
    logic [OffsetW-1:0]   column_offset;
    logic [LengthW-1:0]   total_length;
    logic [ColW-1:0]      short_row_end;
  } rrbd_cfg_t;

  typedef struct packed {
    logic               we;
    logic               pad;
    logic [RowW-1:0]    row_pad;
    logic [OutColW-1:0] col_pad;
    logic [RowW-1:0]    row;
    logic [OutColW-1:0] col;
    logic               done;
    logic [StatusW-1:0] status;
  } rrbd_cmd_t;

endpackage

>>> rtl/core/rrbd_if.sv
// Valid/ready channel interfaces for the deinterleaver input bytes and output writes.
// Depends on rrbd_pkg.
interface rrbd_in_if
  import rrbd_pkg::*;
#(
  parameter int unsigned ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
);
  logic                     valid;
  logic                     ready;
  logic [ELEMENT_WIDTH-1:0] element_value;

  modport source (output valid, output element_value, input ready);
  modport sink (input valid, input element_value, output ready);
endinterface

interface rrbd_out_if
  import rrbd_pkg::*;
#(
  parameter int unsigned ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
);
  logic                     valid;
  logic                     ready;
  logic                     write_enable;
  logic [RowW-1:0]          row_index;
  logic [OutColW-1:0]       column_index;
  logic [ELEMENT_WIDTH-1:0] write_value;
  logic                     is_pad;
  logic                     last_of_item;
  logic                     pass_done;
  logic [StatusW-1:0]       status;

  modport source (
    output valid, output write_enable, output row_index, output column_index,
    output write_value, output is_pad, output last_of_item, output pass_done,
    output status, input ready
  );
  modport sink (
    input valid, input write_enable, input row_index, input column_index,
    input write_value, input is_pad, input last_of_item, input pass_done,
    input status, output ready
  );
endinterface

>>> rtl/core/rs_row_byte_deinterleaver_top.sv
// Top level of the Reed-Solomon row/column byte deinterleaver.
// Depends on rrbd_pkg, rrbd_if, rrbd_cfg, rrbd_fifo, rrbd_front and rrbd_back.
//
// Each accepted byte yields one write of its table position, preceded by a zero
// pad write when the short last row has run out. While the sink stays ready, the
// output moves one write per clock cycle, and bytes are taken one per cycle while
// each yields a single write; once the short last row has run out, one byte in
// every row_count - 1 also brings a pad write, so the input is then accepted on
// row_count - 1 cycles out of every row_count. A two-entry command queue lets the
// front and back parts stall apart. After reset and after each configuration write
// the input is held off while a bit-serial remainder unit (one bit of total_length
// per cycle) derives the last row length and the status code; any configuration
// write also restarts the pass.
module rs_row_byte_deinterleaver_top
  import rrbd_pkg::*;
#(
  parameter int unsigned MAX_ROWS      = DEF_MAX_ROWS,
  parameter int unsigned ROW_LENGTH    = DEF_ROW_LENGTH,
  parameter int unsigned ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  rrbd_in_if.sink             in_i,
  rrbd_out_if.source          out_o
);

  localparam int unsigned QueueW = $bits(rrbd_cmd_t) + ELEMENT_WIDTH;

  rrbd_cfg_t                cfg;
  rrbd_cmd_t                push_cmd;
  rrbd_cmd_t                head_cmd;
  logic [ELEMENT_WIDTH-1:0] push_value;
  logic [ELEMENT_WIDTH-1:0] head_value;
  logic                     push;
  logic                     pop;
  logic                     full;
  logic                     empty;
  logic [QueueW-1:0]        head_word;

  rrbd_cfg #(
    .MAX_ROWS  (MAX_ROWS),
    .ROW_LENGTH(ROW_LENGTH)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  rrbd_front #(
    .ELEMENT_WIDTH(ELEMENT_WIDTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .cfg_we_i(cfg_we_i),
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .cmd_o   (push_cmd),
    .value_o (push_value)
  );

  rrbd_fifo #(
    .WIDTH(QueueW)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i({push_cmd, push_value}),
    .full_o     (full),
    .pop_i      (pop),
    .head_o     (head_word),
    .empty_o    (empty)
  );

  assign {head_cmd, head_value} = head_word;

  rrbd_back #(
    .ELEMENT_WIDTH(ELEMENT_WIDTH)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (head_cmd),
    .value_i(head_value),
    .empty_i(empty),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

>>> rtl/core/rrbd_cfg.sv
// Configuration registers and status check of the deinterleaver.
// A bit-serial remainder unit derives the last row length after each write.
// Depends on rrbd_pkg.
module rrbd_cfg
  import rrbd_pkg::*;
#(
  parameter int unsigned MAX_ROWS   = DEF_MAX_ROWS,
  parameter int unsigned ROW_LENGTH = DEF_ROW_LENGTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output rrbd_cfg_t           cfg_o
);

  localparam int unsigned CmpW = 7;

  logic [RowCountW-1:0] row_count_q;
  logic [FillW-1:0]     fill_width_q;
  logic [OffsetW-1:0]   column_offset_q;
  logic [LengthW-1:0]   total_length_q;
  logic                 busy_q;
  logic [StepCntW-1:0]  cnt_q;
  logic [FillW-1:0]     rem_q;
  logic [FillW-1:0]     rem_d;
  logic [StatusW-1:0]   status_q;
  logic [StatusW-1:0]   status_d;
  logic [ColW-1:0]      short_end_q;
  logic [ColW-1:0]      short_end_d;

  logic [StepCntW-1:0]  bit_idx;
  logic [FillW:0]       shifted;
  logic [FillW-1:0]     last_len;
  logic [LengthW-1:0]   capacity;
  logic [LengthW-1:0]   capacity_m1;
  logic [RowCountW-1:0] rows_m1;
  logic [ColW-1:0]      width_sum;

  always_comb begin
    bit_idx = StepCntW'(LengthW - 1) - cnt_q;
    shifted = {rem_q, total_length_q[bit_idx]};
    if (shifted >= {1'b0, fill_width_q}) begin
      rem_d = FillW'(shifted - {1'b0, fill_width_q});
    end else begin
      rem_d = shifted[FillW-1:0];
    end
  end

  always_comb begin
    last_len    = (rem_q == '0) ? fill_width_q : rem_q;
    rows_m1     = row_count_q - RowCountW'(1);
    capacity    = LengthW'(row_count_q) * LengthW'(fill_width_q);
    capacity_m1 = LengthW'(rows_m1) * LengthW'(fill_width_q);
    width_sum   = {1'b0, fill_width_q} + {1'b0, column_offset_q};
    short_end_d = {1'b0, last_len} + {1'b0, column_offset_q};
    if (row_count_q == '0 || fill_width_q == '0 ||
        CmpW'(row_count_q) > CmpW'(MAX_ROWS)) begin
      status_d = STATUS_ZERO_DIM;
    end else if (width_sum > ColW'(ROW_LENGTH)) begin
      status_d = STATUS_TOO_WIDE;
    end else if (total_length_q > capacity) begin
      status_d = STATUS_TOO_LONG;
    end else if (row_count_q > RowCountW'(1) && total_length_q >= LengthW'(last_len) &&
                 (total_length_q - LengthW'(last_len)) < capacity_m1) begin
      status_d = STATUS_TOO_SHORT;
    end else begin
      status_d = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q     <= RESET_ROW_COUNT;
      fill_width_q    <= RESET_FILL_WIDTH;
      column_offset_q <= RESET_COLUMN_OFFSET;
      total_length_q  <= RESET_TOTAL_LENGTH;
      busy_q          <= 1'b1;
      cnt_q           <= '0;
      rem_q           <= '0;
      status_q        <= STATUS_OK;
      short_end_q     <= '0;
    end else if (cfg_we_i) begin
      case (rrbd_reg_e'(cfg_index_i))
        REG_ROW_COUNT:     row_count_q     <= cfg_data_i[RowCountW-1:0];
        REG_FILL_WIDTH:    fill_width_q    <= cfg_data_i[FillW-1:0];
        REG_COLUMN_OFFSET: column_offset_q <= cfg_data_i[OffsetW-1:0];
        REG_TOTAL_LENGTH:  total_length_q  <= cfg_data_i[LengthW-1:0];
        default:           row_count_q     <= row_count_q;
      endcase
      busy_q <= 1'b1;
      cnt_q  <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q != DIV_STEPS) begin
        rem_q <= rem_d;
        cnt_q <= cnt_q + StepCntW'(1);
      end else begin
        status_q    <= status_d;
        short_end_q <= short_end_d;
        busy_q      <= 1'b0;
      end
    end
  end

  assign cfg_o.busy          = busy_q;
  assign cfg_o.status        = status_q;
  assign cfg_o.row_count     = row_count_q;
  assign cfg_o.column_offset = column_offset_q;
  assign cfg_o.total_length  = total_length_q;
  assign cfg_o.short_row_end = short_end_q;

endmodule

>>> rtl/core/rrbd_fifo.sv
// Two-entry queue between the front and back parts of the deinterleaver.
// Has no dependencies; carries an opaque word.
module rrbd_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] head_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> rtl/core/rrbd_front.sv
// Front part of the deinterleaver: accepts bytes, walks the row/column counters
// and issues one command per transaction to the queue. Depends on rrbd_pkg, rrbd_if.
module rrbd_front
  import rrbd_pkg::*;
#(
  parameter int unsigned ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rrbd_cfg_t                cfg_i,
  input  logic                     cfg_we_i,
  rrbd_in_if.sink                  in_i,
  input  logic                     full_i,
  output logic                     push_o,
  output rrbd_cmd_t                cmd_o,
  output logic [ELEMENT_WIDTH-1:0] value_o
);

  logic [RowW-1:0]      row_q, row_d;
  logic [ColW-1:0]      col_q, col_d;
  logic [LengthW-1:0]   taken_q, taken_d;

  logic                 accept;
  logic                 good;
  logic                 first;
  logic                 done;
  logic                 pad;
  logic [RowW-1:0]      row_e;
  logic [ColW-1:0]      col_e;
  logic [RowW-1:0]      row_a;
  logic [ColW-1:0]      col_a;
  logic [RowW-1:0]      row_n;
  logic                 wrap;
  logic [RowCountW-1:0] rows_m1;

  assign in_i.ready = !cfg_i.busy && !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign push_o     = accept;

  always_comb begin
    good    = (cfg_i.status == STATUS_OK) && (cfg_i.total_length != '0);
    first   = (taken_q == '0);
    row_e   = first ? '0 : row_q;
    col_e   = first ? {1'b0, cfg_i.column_offset} : col_q;
    done    = ({1'b0, taken_q} + (LengthW+1)'(1)) >= {1'b0, cfg_i.total_length};
    rows_m1 = cfg_i.row_count - RowCountW'(1);
    pad     = (RowCountW'(row_e) == rows_m1) && (col_e >= cfg_i.short_row_end);
    row_a   = pad ? '0 : row_e;
    col_a   = pad ? col_e + ColW'(1) : col_e;
    row_n   = row_a + RowW'(1);
    wrap    = (RowCountW'(row_n) == cfg_i.row_count) || (row_n == '0);
    if (!good || done) begin
      row_d   = '0;
      col_d   = '0;
      taken_d = '0;
    end else begin
      row_d   = wrap ? '0 : row_n;
      col_d   = wrap ? col_a + ColW'(1) : col_a;
      taken_d = taken_q + LengthW'(1);
    end
  end

  always_comb begin
    cmd_o.we      = good;
    cmd_o.pad     = good && pad;
    cmd_o.row_pad = row_e;
    cmd_o.col_pad = col_e[OutColW-1:0];
    cmd_o.row     = good ? row_a : '0;
    cmd_o.col     = good ? col_a[OutColW-1:0] : '0;
    cmd_o.done    = good && done;
    cmd_o.status  = cfg_i.status;
    value_o       = good ? in_i.element_value : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      taken_q <= '0;
    end else if (cfg_we_i) begin
      row_q   <= '0;
      col_q   <= '0;
      taken_q <= '0;
    end else if (accept) begin
      row_q   <= row_d;
      col_q   <= col_d;
      taken_q <= taken_d;
    end
  end

endmodule

>>> rtl/core/rrbd_back.sv
// Back part of the deinterleaver: expands each queued command into its pad
// and data writes through a registered output. Depends on rrbd_pkg, rrbd_if.
module rrbd_back
  import rrbd_pkg::*;
#(
  parameter int unsigned ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rrbd_cmd_t                cmd_i,
  input  logic [ELEMENT_WIDTH-1:0] value_i,
  input  logic                     empty_i,
  output logic                     pop_o,
  rrbd_out_if.source               out_o
);

  logic                     valid_q;
  logic                     pad_sent_q;
  logic                     load;
  logic                     emit_pad;
  logic                     we_q;
  logic [RowW-1:0]          row_q;
  logic [OutColW-1:0]       col_q;
  logic [ELEMENT_WIDTH-1:0] value_q;
  logic                     is_pad_q;
  logic                     last_q;
  logic                     done_q;
  logic [StatusW-1:0]       status_q;

  assign load     = (!valid_q || out_o.ready) && !empty_i;
  assign emit_pad = cmd_i.pad && !pad_sent_q;
  assign pop_o    = load && !emit_pad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      pad_sent_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q    <= 1'b1;
        pad_sent_q <= emit_pad;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (emit_pad) begin
        we_q     <= 1'b1;
        row_q    <= cmd_i.row_pad;
        col_q    <= cmd_i.col_pad;
        value_q  <= '0;
        is_pad_q <= 1'b1;
        last_q   <= 1'b0;
        done_q   <= cmd_i.done;
        status_q <= STATUS_OK;
      end else begin
        we_q     <= cmd_i.we;
        row_q    <= cmd_i.row;
        col_q    <= cmd_i.col;
        value_q  <= value_i;
        is_pad_q <= 1'b0;
        last_q   <= 1'b1;
        done_q   <= cmd_i.done;
        status_q <= cmd_i.status;
      end
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.write_enable = we_q;
  assign out_o.row_index    = row_q;
  assign out_o.column_index = col_q;
  assign out_o.write_value  = value_q;
  assign out_o.is_pad       = is_pad_q;
  assign out_o.last_of_item = last_q;
  assign out_o.pass_done    = done_q;
  assign out_o.status       = status_q;

endmodule

>>> bench/tb_rs_row_byte_deinterleaver_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for rs_row_byte_deinterleaver_top: drives bytes and register writes,
// predicts every table write and pad write, and checks them field by field.
// Depends on rrbd_pkg, the rrbd_in_if/rrbd_out_if interfaces and the top level.
module tb_rs_row_byte_deinterleaver_top
  import rrbd_pkg::*;
();

  localparam int unsigned MAX_ROWS   = DEF_MAX_ROWS;
  localparam int unsigned ROW_LENGTH = DEF_ROW_LENGTH;

  typedef enum int {IDLE_NONE, IDLE_SOURCE, IDLE_SINK, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic               we;
    logic [RowW-1:0]    row;
    logic [OutColW-1:0] col;
    logic [7:0]         value;
    logic               pad;
    logic               last;
    logic               done;
    logic [StatusW-1:0] status;
  } table_write_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  rrbd_in_if  #(.ELEMENT_WIDTH(8)) in_if ();
  rrbd_out_if #(.ELEMENT_WIDTH(8)) out_if ();

  rs_row_byte_deinterleaver_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  logic [RowCountW-1:0] row_cnt;
  logic [FillW-1:0]     fill_w;
  logic [OffsetW-1:0]   col_off;
  logic [LengthW-1:0]   pass_len;
  logic [RowW-1:0]      walk_row;
  logic [ColW-1:0]      walk_col;
  logic [LengthW-1:0]   taken;
  logic [ColW-1:0]      row_end;

  table_write_t pending_writes[$];
  int unsigned  src_pct;
  int unsigned  sink_pct;
  int unsigned  hold_cycles;
  int unsigned  fail_count;
  int unsigned  n_bytes;
  int unsigned  n_writes;
  int unsigned  n_pads;
  int unsigned  n_refused;
  int unsigned  n_setups;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("tb_rs_row_byte_deinterleaver_top: errors");
    $finish;
  end

  function automatic void restart_walk();
    walk_row = '0;
    walk_col = '0;
    taken    = '0;
    row_end  = '0;
  endfunction

  function automatic int unsigned tail_length();
    int unsigned rem;
    rem = int'(pass_len) % int'(fill_w);
    return (rem == 0) ? int'(fill_w) : rem;
  endfunction

  function automatic logic [StatusW-1:0] setup_status();
    int unsigned rows;
    int unsigned fill;
    int unsigned len;
    int unsigned tail;
    rows = int'(row_cnt);
    fill = int'(fill_w);
    len  = int'(pass_len);
    if (rows == 0 || fill == 0 || rows > MAX_ROWS) return STATUS_ZERO_DIM;
    if (fill + int'(col_off) > ROW_LENGTH) return STATUS_TOO_WIDE;
    if (len > rows * fill) return STATUS_TOO_LONG;
    tail = tail_length();
    if (rows > 1 && len >= tail && len - tail < (rows - 1) * fill) return STATUS_TOO_SHORT;
    return STATUS_OK;
  endfunction

  function automatic void apply_reg(input rrbd_reg_e idx, input logic [CfgDataW-1:0] data);
    case (idx)
      REG_ROW_COUNT:     row_cnt  = data[RowCountW-1:0];
      REG_FILL_WIDTH:    fill_w   = data[FillW-1:0];
      REG_COLUMN_OFFSET: col_off  = data[OffsetW-1:0];
      REG_TOTAL_LENGTH:  pass_len = data[LengthW-1:0];
      default: ;
    endcase
    restart_walk();
  endfunction

  function automatic void walk_byte(input logic [7:0] value);
    table_write_t       w;
    table_write_t       pad_w;
    logic [StatusW-1:0] st;
    logic               done;
    st = setup_status();
    w = '0;
    w.last = 1'b1;
    if (st != STATUS_OK || pass_len == 0) begin
      w.status = st;
      restart_walk();
      pending_writes.push_back(w);
      return;
    end
    if (taken == 0) begin
      walk_row = '0;
      walk_col = {1'b0, col_off};
      row_end  = ColW'(tail_length() + int'(col_off));
    end
    done = (int'(taken) + 1 >= int'(pass_len));
    if (int'(walk_row) == int'(row_cnt) - 1 && walk_col >= row_end) begin
      pad_w = '0;
      pad_w.we   = 1'b1;
      pad_w.row  = walk_row;
      pad_w.col  = walk_col[OutColW-1:0];
      pad_w.pad  = 1'b1;
      pad_w.done = done;
      pending_writes.push_back(pad_w);
      walk_row = '0;
      walk_col = walk_col + ColW'(1);
    end
    w.we    = 1'b1;
    w.row   = walk_row;
    w.col   = walk_col[OutColW-1:0];
    w.value = value;
    w.done  = done;
    pending_writes.push_back(w);
    walk_row = walk_row + RowW'(1);
    if (walk_row == 0 || int'(walk_row) == int'(row_cnt)) begin
      walk_row = '0;
      walk_col = walk_col + ColW'(1);
    end
    if (done) restart_walk();
    else taken = taken + LengthW'(1);
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic check_write();
    table_write_t want;
    n_writes++;
    if (pending_writes.size() == 0) begin
      $error("unexpected write: row %0d col %0d value %0d", out_if.row_index,
             out_if.column_index, out_if.write_value);
      fail_count++;
      return;
    end
    want = pending_writes.pop_front();
    if (want.pad) n_pads++;
    if (want.status != STATUS_OK) n_refused++;
    compare_field("write_enable", 8'(want.we), 8'(out_if.write_enable));
    compare_field("row_index", 8'(want.row), 8'(out_if.row_index));
    compare_field("column_index", want.col, out_if.column_index);
    compare_field("write_value", want.value, out_if.write_value);
    compare_field("is_pad", 8'(want.pad), 8'(out_if.is_pad));
    compare_field("last_of_item", 8'(want.last), 8'(out_if.last_of_item));
    compare_field("pass_done", 8'(want.done), 8'(out_if.pass_done));
    compare_field("status", 8'(want.status), 8'(out_if.status));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) check_write();
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_if.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_if.ready <= !($urandom_range(99) < sink_pct);
      end
    end
  end

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE:   begin src_pct = 0;  sink_pct = 0;  end
      IDLE_SOURCE: begin src_pct = 83; sink_pct = 0;  end
      IDLE_SINK:   begin src_pct = 0;  sink_pct = 83; end
      IDLE_BOTH:   begin src_pct = 8;  sink_pct = 8;  end
      default:     begin src_pct = 0;  sink_pct = 0;  end
    endcase
  endtask

  // Called and returns at a falling edge; valid stays high so back-to-back bytes need no gap.
  task automatic send_byte(input logic [7:0] value);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < src_pct) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.element_value <= value;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    walk_byte(value);
    n_bytes++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_writes.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic put_reg(input rrbd_reg_e idx, input logic [CfgDataW-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    apply_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic load_setup(input logic [CfgDataW-1:0] rows, input logic [CfgDataW-1:0] fill,
                            input logic [CfgDataW-1:0] off, input logic [CfgDataW-1:0] len);
    wait_idle();
    cfg_we_i <= 1'b1;
    put_reg(REG_ROW_COUNT, rows);
    put_reg(REG_FILL_WIDTH, fill);
    put_reg(REG_COLUMN_OFFSET, off);
    put_reg(REG_TOTAL_LENGTH, len);
    cfg_we_i <= 1'b0;
    n_setups++;
  endtask

  task automatic test_reset_setup();
    set_idling(IDLE_NONE);
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  task automatic test_bad_setups();
    load_setup(0, 4, 0, 4);
    send_byte(8'hA5);
    load_setup(17, 4, 0, 4);
    send_byte(8'h5A);
    load_setup(2, 0, 0, 4);
    send_byte(8'h01);
    load_setup(2, 200, 56, 4);
    send_byte(8'h80);
    load_setup(2, 4, 0, 9);
    send_byte(8'h7F);
    load_setup(3, 4, 0, 6);
    send_byte(8'hFE);
    load_setup(16, 255, 0, 4096);
    send_byte(8'h33);
    load_setup(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF);
    send_byte(8'hCC);
  endtask

  task automatic test_short_row();
    logic [7:0] pattern[13];
    pattern = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'hFE, 8'h7F, 8'h0F, 8'hF0,
                8'h11, 8'hEE, 8'h3C};
    load_setup(3, 4, 10, 10);
    foreach (pattern[i]) send_byte(pattern[i]);
  endtask

  task automatic test_random_passes();
    int unsigned rows;
    int unsigned fill;
    int unsigned off;
    int unsigned len;
    int unsigned count;
    for (int phase = 0; phase < 13; phase++) begin
      count = 150;
      if (phase == 0) begin
        load_setup(16, 1, 254, 16);
      end else if (phase == 1) begin
        load_setup(1, 255, 0, 255);
        count = 300;
      end else if (phase % 5 == 4) begin
        load_setup(13'($urandom), 13'($urandom), 13'($urandom), 13'($urandom));
        count = 8;
      end else begin
        rows = $urandom_range(16, 1);
        fill = ($urandom_range(3) == 0) ? $urandom_range(255, 1) : $urandom_range(12, 1);
        off  = $urandom_range(255 - fill, 0);
        len  = ($urandom_range(9) == 0) ? 0 : (rows - 1) * fill + $urandom_range(fill, 1);
        load_setup(CfgDataW'(rows), CfgDataW'(fill), CfgDataW'(off), CfgDataW'(len));
      end
      set_idling(idle_mode_e'(phase % 4));
      repeat (count) send_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic test_output_backpressure();
    load_setup(5, 7, 100, 30);
    set_idling(IDLE_NONE);
    @(posedge clk_i);
    hold_cycles = 300;
    @(negedge clk_i);
    repeat (60) send_byte(8'($urandom_range(255)));
  endtask

  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_index_i         = REG_ROW_COUNT;
    cfg_data_i          = '0;
    in_if.valid         = 1'b0;
    in_if.element_value = '0;
    src_pct             = 0;
    sink_pct            = 0;
    hold_cycles         = 0;
    fail_count          = 0;
    n_bytes             = 0;
    n_writes            = 0;
    n_pads              = 0;
    n_refused           = 0;
    n_setups            = 0;
    row_cnt             = RESET_ROW_COUNT;
    fill_w              = RESET_FILL_WIDTH;
    col_off             = RESET_COLUMN_OFFSET;
    pass_len            = RESET_TOTAL_LENGTH;
    restart_walk();
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_setup();
    test_bad_setups();
    test_short_row();
    test_output_backpressure();
    test_random_passes();

    wait_idle();
    repeat (20) @(negedge clk_i);
    $display("Sent %0d bytes under %0d register setups; checked %0d results.",
             n_bytes, n_setups, n_writes);
    $display("Among them %0d pad writes and %0d refusals for a bad setup.", n_pads, n_refused);
    if (fail_count == 0 && pending_writes.size() == 0) begin
      $display("tb_rs_row_byte_deinterleaver_top: clean");
    end else begin
      $display("tb_rs_row_byte_deinterleaver_top: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/rrbd_pkg.sv
rtl/core/rrbd_if.sv
rtl/core/rrbd_cfg.sv
rtl/core/rrbd_fifo.sv
rtl/core/rrbd_front.sv
rtl/core/rrbd_back.sv
rtl/core/rs_row_byte_deinterleaver_top.sv
bench/tb_rs_row_byte_deinterleaver_top.sv
